### design/slip_packet_deframer_unit_macros.svh
// assertion helpers for the slip deframer
`ifndef SLIP_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define SLIP_PACKET_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SLIPDF_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("slip deframer check failed");

// next-cycle implication, checked outside reset
`define SLIPDF_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("slip deframer check failed");

`endif

### design/slipdf_pkg.sv
`timescale 1ns / 1ps

package slipdf_pkg;

    localparam logic [7:0] CODE_FEND  = 8'hC0;
    localparam logic [7:0] CODE_FESC  = 8'hDB;
    localparam logic [7:0] CODE_TFEND = 8'hDC;
    localparam logic [7:0] CODE_TFESC = 8'hDD;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_ESC  = 2'd2
    } t_phase;

    // decoder verdict for one byte
    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic       packet_end;
        logic       bad_packet;
        t_phase     phase;
        logic       esc_err;
    } t_dec;

endpackage

### design/slip_packet_deframer_unit.sv
`timescale 1ns / 1ps
// an accepted beat is held in the input register, and its result then in the result register
// throughput: one beat per cycle while the output is not stalled; the parse state loop is a single decode step
// a stalled output holds back the input register and thus the input ready
// reset: synchronous, active low; clears both valid flags, parse phase and escape error
// no clearing pass; the block accepts beats in the first cycle after reset
`include "slip_packet_deframer_unit_macros.svh"

module slip_packet_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_flush,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_packet_end,
    output logic       o_bad_packet
);
    import slipdf_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_flush;
    t_phase     r_phase;
    logic       r_esc_err;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       r_out_bad;
    logic       n_out_valid;
    logic       w_adv;
    logic       w_take;
    t_dec       w_dec;

    slipdf_decoder u_dec (
        .i_byte   (r_in_byte),
        .i_flush  (r_in_flush),
        .i_phase  (r_phase),
        .i_esc_err(r_esc_err),
        .o_dec    (w_dec)
    );

    // result slot is free at this edge
    assign w_adv      = !r_out_valid || i_out_ready;
    // held beat is decoded and retired
    assign w_take     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = w_take && w_dec.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_esc_err   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_take) begin
                r_phase   <= w_dec.phase;
                r_esc_err <= w_dec.esc_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_in_byte;
            r_in_flush <= i_flush;
        end
        if (w_take && w_dec.emit) begin
            r_out_byte <= w_dec.out_byte;
            r_out_end  <= w_dec.packet_end;
            r_out_bad  <= w_dec.bad_packet;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_packet_end = r_out_end;
    assign o_bad_packet = r_out_bad;

    `SLIPDF_ASSERT_IMPL(a_data_not_bad, i_clk, i_rst_n, r_out_valid && !r_out_end, !r_out_bad)
    `SLIPDF_ASSERT_IMPL(a_end_zero_byte, i_clk, i_rst_n, r_out_valid && r_out_end, r_out_byte == 8'h00)
    `SLIPDF_ASSERT_NEXT(a_end_to_idle, i_clk, i_rst_n, w_take && w_dec.packet_end, r_phase == PH_IDLE && !r_esc_err)
    `SLIPDF_ASSERT_IMPL(a_idle_quiet, i_clk, i_rst_n, w_take && r_phase == PH_IDLE && !r_in_flush, !w_dec.emit)

endmodule

### design/slipdf_decoder.sv
`timescale 1ns / 1ps

module slipdf_decoder (
    input  logic [7:0]           i_byte,
    input  logic                 i_flush,
    input  slipdf_pkg::t_phase   i_phase,
    input  logic                 i_esc_err,
    output slipdf_pkg::t_dec     o_dec
);
    import slipdf_pkg::*;

    always_comb begin
        o_dec            = '0;
        o_dec.phase      = i_phase;
        o_dec.esc_err    = i_esc_err;
        case (i_phase)
            PH_DATA, PH_ESC: begin
                if (i_byte == CODE_FEND) begin
                    o_dec.emit       = 1'b1;
                    o_dec.packet_end = 1'b1;
                    o_dec.bad_packet = i_esc_err | (i_phase == PH_ESC);
                    o_dec.phase      = PH_IDLE;
                    o_dec.esc_err    = 1'b0;
                end else if (i_esc_err) begin
                    // packet already bad: swallow until END
                    o_dec.phase = PH_DATA;
                end else if (i_phase == PH_ESC) begin
                    if (i_byte == CODE_TFEND) begin
                        o_dec.emit     = 1'b1;
                        o_dec.out_byte = CODE_FEND;
                    end else if (i_byte == CODE_TFESC) begin
                        o_dec.emit     = 1'b1;
                        o_dec.out_byte = CODE_FESC;
                    end else begin
                        o_dec.esc_err = 1'b1;
                    end
                    o_dec.phase = PH_DATA;
                end else if (i_byte == CODE_FESC) begin
                    o_dec.phase = PH_ESC;
                end else begin
                    o_dec.emit     = 1'b1;
                    o_dec.out_byte = i_byte;
                end
            end
            default: begin
                if (i_byte == CODE_FEND) begin
                    o_dec.phase   = PH_DATA;
                    o_dec.esc_err = 1'b0;
                end
            end
        endcase

        // flush drops whatever packet is still open after this byte
        if (i_flush && (o_dec.phase != PH_IDLE)) begin
            o_dec.emit       = 1'b1;
            o_dec.out_byte   = '0;
            o_dec.packet_end = 1'b1;
            o_dec.bad_packet = 1'b1;
            o_dec.phase      = PH_IDLE;
            o_dec.esc_err    = 1'b0;
        end
    end

endmodule
